FILE: hdl/e2p_pkg.sv
// ----------------------------------------------------------------------------
// e2p_pkg
// types, register indexes and the arctangent table shared by the remap block
// ----------------------------------------------------------------------------
package e2p_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int COL_W      = 12;
	localparam int SRC_COORD_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_DEG    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_DEG   = 3'd5;

	// degrees to angle units: reciprocal of 360 for the rounding division
	localparam int DEG_TURN    = 360;
	localparam int DEG_ROUND   = 180;
	localparam int RECIP_SHIFT = 27;
	localparam int RECIP_360   = 372827;

	typedef logic [31:0] turn32_t;

	// atan(2^-i) in units of 2^-32 turn
	localparam turn32_t ATAN_TURN32 [0:31] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	// table entry rounded to units of 2^-ab turn
	function automatic logic [32:0] atan_step(logic [4:0] i, int ab);
		return ({1'b0, ATAN_TURN32[i]} + (33'd1 << (31 - ab))) >> (32 - ab);
	endfunction

endpackage

FILE: hdl/e2p_if.sv
// ----------------------------------------------------------------------------
// e2p channel interfaces
// coordinate input, source address output and register write channels
// ----------------------------------------------------------------------------
interface e2p_coord_if;
	logic                        valid;
	logic                        ready;
	logic [e2p_pkg::COL_W-1:0]   out_col;
	logic [e2p_pkg::COL_W-1:0]   out_line;
	modport source(output valid, output out_col, output out_line, input ready);
	modport sink(input valid, input out_col, input out_line, output ready);
endinterface

interface e2p_addr_if;
	logic                              valid;
	logic                              ready;
	logic [e2p_pkg::SRC_COORD_W-1:0]   src_x;
	logic [e2p_pkg::SRC_COORD_W-1:0]   src_y;
	modport source(output valid, output src_x, output src_y, input ready);
	modport sink(input valid, input src_x, input src_y, output ready);
endinterface

interface e2p_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [e2p_pkg::CFG_IDX_W-1:0]    index;
	logic [e2p_pkg::CFG_DATA_W-1:0]   data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: hdl/equirect_to_perspective_remap_top.sv
// ----------------------------------------------------------------------------
// equirect_to_perspective_remap_top
// maps a perspective view pixel to its equirectangular source pixel
// ----------------------------------------------------------------------------
// usage
//   coord: one beat per view pixel (out_col, out_line), valid/ready
//   addr:  one beat per pixel with src_x (wrapped) and src_y (clamped)
//   cfg:   register writes (index, data), always ready; write only while
//          no pixel is in flight
// latency: ANGLE_BITS + 4 cycles from coord beat to addr beat, set by one
//   register stage per cordic iteration of the two arctangent lanes plus
//   the entry, angle, multiply and wrap stages
// throughput: one beat per cycle; every stage has its own valid bit and an
//   empty stage keeps taking data while the output is stalled
// stall: when addr.ready is low the pipeline fills and then coord.ready
//   drops; nothing is dropped or repeated
// reset: all stages empty, registers return to 640x480 view, 4096x2048
//   source, pan 180, tilt 0
// ----------------------------------------------------------------------------
module equirect_to_perspective_remap_top #(
	parameter int OUT_DIM_MAX = 4096,
	parameter int SRC_DIM_MAX = 16384,
	parameter int ANGLE_BITS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	e2p_cfg_if.sink    cfg,
	e2p_coord_if.sink  coord,
	e2p_addr_if.source addr
);
	import e2p_pkg::*;

	localparam int OWW = $clog2(OUT_DIM_MAX + 1);
	localparam int SWW = $clog2(SRC_DIM_MAX + 1);
	localparam int DW  = ((OWW > COL_W) ? OWW : COL_W) + 2;
	localparam int CW  = DW + 2 + 32;
	localparam int AU  = 1 << ANGLE_BITS;
	localparam int ZW  = ANGLE_BITS + 2;
	localparam int UW  = ANGLE_BITS + 1;
	localparam int BW  = ANGLE_BITS + 3;
	localparam int MW  = ANGLE_BITS + 4;
	localparam int PW  = SWW + 1 + MW;
	localparam int VW  = 18;
	localparam int KW  = 19;
	localparam int QW  = VW + KW - RECIP_SHIFT;
	localparam int Q_UNIT = AU / DEG_TURN;
	localparam int R_UNIT = AU % DEG_TURN;
	localparam int NS  = ANGLE_BITS + 4;
	localparam int ST_P1 = ANGLE_BITS + 1;
	localparam int ST_P2 = ANGLE_BITS + 2;
	localparam int ST_P3 = ANGLE_BITS + 3;

	// configuration registers
	logic [12:0] out_width_q, out_height_q;
	logic [14:0] src_width_q, src_height_q;
	logic [8:0]  pan_deg_q;
	logic [7:0]  tilt_deg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q  <= 13'd640;
			out_height_q <= 13'd480;
			src_width_q  <= 15'd4096;
			src_height_q <= 15'd2048;
			pan_deg_q    <= 9'd180;
			tilt_deg_q   <= 8'd0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_OUT_WIDTH:  out_width_q  <= cfg.data[12:0];
				REG_OUT_HEIGHT: out_height_q <= cfg.data[12:0];
				REG_SRC_WIDTH:  src_width_q  <= cfg.data[14:0];
				REG_SRC_HEIGHT: src_height_q <= cfg.data[14:0];
				REG_PAN_DEG:    pan_deg_q    <= cfg.data[8:0];
				REG_TILT_DEG:   tilt_deg_q   <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// saturated dimensions
	logic [OWW-1:0] ow_c, oh_c, fw_c, f_c;
	logic [SWW-1:0] sw_c, sh_c, h_c;

	assign ow_c = (int'(out_width_q) > OUT_DIM_MAX) ? OWW'(OUT_DIM_MAX) : OWW'(out_width_q);
	assign oh_c = (int'(out_height_q) > OUT_DIM_MAX) ? OWW'(OUT_DIM_MAX) : OWW'(out_height_q);
	assign sw_c = (int'(src_width_q) > SRC_DIM_MAX) ? SWW'(SRC_DIM_MAX) : SWW'(src_width_q);
	assign sh_c = (int'(src_height_q) > SRC_DIM_MAX) ? SWW'(SRC_DIM_MAX) : SWW'(src_height_q);
	assign fw_c = ow_c >> 1;
	assign f_c  = (fw_c == '0) ? OWW'(1) : fw_c;
	assign h_c  = sh_c >> 1;

	// pan and tilt in angle units, rounded division by 360
	logic [8:0]         pan_m;
	logic [VW-1:0]      pan_v;
	logic [VW+KW-1:0]   pan_prod_q;
	logic [QW-1:0]      pan_q0;
	logic [UW-1:0]      pan_u_q;
	logic               tilt_neg;
	logic [7:0]         tilt_m;
	logic [VW-1:0]      tilt_v;
	logic [VW+KW-1:0]   tilt_prod_q;
	logic [QW-1:0]      tilt_q0;
	logic [UW-1:0]      tilt_mag;
	logic signed [UW-1:0] tilt_u_q;
	int                 pan_r, tilt_r;

	assign pan_m    = (pan_deg_q >= 9'(DEG_TURN)) ? pan_deg_q - 9'(DEG_TURN) : pan_deg_q;
	assign pan_v    = VW'(int'(pan_m) * R_UNIT + DEG_ROUND);
	assign pan_q0   = pan_prod_q[VW+KW-1:RECIP_SHIFT];
	assign pan_r    = int'(pan_v) - int'(pan_q0) * DEG_TURN;
	assign tilt_neg = tilt_deg_q[7];
	assign tilt_m   = tilt_neg ? 8'(-tilt_deg_q) : tilt_deg_q;
	assign tilt_v   = VW'(int'(tilt_m) * R_UNIT + DEG_ROUND);
	assign tilt_q0  = tilt_prod_q[VW+KW-1:RECIP_SHIFT];
	assign tilt_r   = int'(tilt_v) - int'(tilt_q0) * DEG_TURN;
	assign tilt_mag = UW'(int'(tilt_m) * Q_UNIT + int'(tilt_q0) + ((tilt_r >= DEG_TURN) ? 1 : 0));

	always_ff @(posedge clk) begin
		pan_prod_q  <= (VW+KW)'(pan_v) * (VW+KW)'(RECIP_360);
		tilt_prod_q <= (VW+KW)'(tilt_v) * (VW+KW)'(RECIP_360);
		pan_u_q     <= UW'(int'(pan_m) * Q_UNIT + int'(pan_q0) +
			((pan_r >= DEG_TURN) ? 1 : 0));
		tilt_u_q    <= tilt_neg ? -signed'(tilt_mag) : signed'(tilt_mag);
	end

	// stage valid bits and enables
	logic [NS-1:0] vld_q;
	logic [NS:0]   en;

	always_comb begin
		en[NS] = addr.ready;
		for (int k = NS - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign coord.ready = en[0];
	assign addr.valid  = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= coord.valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// entry stage: offsets from the view center
	logic signed [DW-1:0] dh_c, dv_c;

	assign dh_c = DW'(coord.out_col) - DW'(ow_c >> 1);
	assign dv_c = DW'(oh_c >> 1) - DW'(coord.out_line);

	logic signed [CW-1:0] xh_s [0:ANGLE_BITS];
	logic signed [CW-1:0] yh_s [0:ANGLE_BITS];
	logic signed [ZW-1:0] zh_s [0:ANGLE_BITS];
	logic                 nzh_s [0:ANGLE_BITS];
	logic signed [CW-1:0] xv_s [0:ANGLE_BITS];
	logic signed [CW-1:0] yv_s [0:ANGLE_BITS];
	logic signed [ZW-1:0] zv_s [0:ANGLE_BITS];
	logic                 nzv_s [0:ANGLE_BITS];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			xh_s[0]  <= {{(CW-32-OWW){1'b0}}, f_c, 32'd0};
			yh_s[0]  <= {{(CW-32-DW){dh_c[DW-1]}}, dh_c, 32'd0};
			zh_s[0]  <= '0;
			nzh_s[0] <= (dh_c != '0);
			xv_s[0]  <= {{(CW-32-OWW){1'b0}}, f_c, 32'd0};
			yv_s[0]  <= {{(CW-32-DW){dv_c[DW-1]}}, dv_c, 32'd0};
			zv_s[0]  <= '0;
			nzv_s[0] <= (dv_c != '0);
		end
	end

	// cordic vectoring, one iteration per stage for both lanes
	for (genvar i = 0; i < ANGLE_BITS; i++) begin : g_cordic
		localparam logic signed [ZW-1:0] T_I = ZW'(atan_step(5'(i), ANGLE_BITS));
		logic signed [CW-1:0] xhs, yhs, xvs, yvs;

		assign xhs = xh_s[i] >>> i;
		assign yhs = yh_s[i] >>> i;
		assign xvs = xv_s[i] >>> i;
		assign yvs = yv_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				nzh_s[i+1] <= nzh_s[i];
				nzv_s[i+1] <= nzv_s[i];
				if (yh_s[i] < 0) begin
					xh_s[i+1] <= xh_s[i] - yhs;
					yh_s[i+1] <= yh_s[i] + xhs;
					zh_s[i+1] <= zh_s[i] - T_I;
				end else begin
					xh_s[i+1] <= xh_s[i] + yhs;
					yh_s[i+1] <= yh_s[i] - xhs;
					zh_s[i+1] <= zh_s[i] + T_I;
				end
				if (yv_s[i] < 0) begin
					xv_s[i+1] <= xv_s[i] - yvs;
					yv_s[i+1] <= yv_s[i] + xvs;
					zv_s[i+1] <= zv_s[i] - T_I;
				end else begin
					xv_s[i+1] <= xv_s[i] + yvs;
					yv_s[i+1] <= yv_s[i] - xvs;
					zv_s[i+1] <= zv_s[i] + T_I;
				end
			end
		end
	end

	// angle stage: view angles, horizontal angle reduced by a turn
	logic signed [ZW-1:0] zh_eff, zv_eff;
	logic signed [BW-1:0] b_c, al_c, al_abs;
	logic signed [BW-1:0] alr_c;
	logic signed [MW-1:0] m4_s1;
	logic signed [BW-1:0] alr_s1;

	assign zh_eff = nzh_s[ANGLE_BITS] ? zh_s[ANGLE_BITS] : '0;
	assign zv_eff = nzv_s[ANGLE_BITS] ? zv_s[ANGLE_BITS] : '0;
	assign b_c    = BW'(tilt_u_q) + BW'(zv_eff);
	assign al_c   = signed'(BW'(pan_u_q)) + BW'(zh_eff);
	assign al_abs = (al_c < 0) ? -al_c : al_c;
	assign alr_c  = (al_c < 0) ? -(al_abs & BW'(AU - 1)) : (al_abs & BW'(AU - 1));

	always_ff @(posedge clk) begin
		if (en[ST_P1]) begin
			m4_s1  <= signed'(MW'(AU)) - (MW'(b_c) <<< 2);
			alr_s1 <= alr_c;
		end
	end

	// multiply stage
	logic signed [PW-1:0] py_s2, px_s2;

	always_ff @(posedge clk) begin
		if (en[ST_P2]) begin
			py_s2 <= signed'({1'b0, h_c}) * m4_s1;
			px_s2 <= signed'({1'b0, sw_c}) * alr_s1;
		end
	end

	// rounding, clamp and wrap stage
	logic signed [PW-1:0] yy_c, xx_c, shm1_c, swe_c, yc_c, xw_c;
	logic [SRC_COORD_W-1:0] src_x_s3, src_y_s3;

	assign yy_c   = (py_s2 + PW'(AU / 2)) >>> ANGLE_BITS;
	assign xx_c   = (px_s2 + PW'(AU / 2)) >>> ANGLE_BITS;
	assign shm1_c = signed'(PW'(sh_c)) - PW'(1);
	assign swe_c  = signed'(PW'(sw_c));

	always_comb begin
		yc_c = yy_c;
		if (yc_c > shm1_c) begin
			yc_c = shm1_c;
		end
		if (yc_c < 0) begin
			yc_c = '0;
		end
		xw_c = xx_c;
		if (xw_c < 0) begin
			xw_c = xw_c + swe_c;
		end else if (xw_c >= swe_c) begin
			xw_c = xw_c - swe_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_P3]) begin
			src_x_s3 <= xw_c[SRC_COORD_W-1:0];
			src_y_s3 <= yc_c[SRC_COORD_W-1:0];
		end
	end

	assign addr.src_x = src_x_s3;
	assign addr.src_y = src_y_s3;

`ifndef SYNTHESIS
	a_ready_only_on_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!coord.ready |-> (addr.valid && !addr.ready))
		else $error("input stalled without a stalled full pipeline");

	a_entry_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(coord.valid && coord.ready) |=> vld_q[0])
		else $error("accepted beat missing from entry stage");

	a_output_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(addr.valid && addr.ready && !vld_q[NS-2]) |=> !addr.valid)
		else $error("output beat repeated");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(addr.valid && sh_c != '0) |-> (int'(addr.src_y) < int'(sh_c)))
		else $error("source row beyond source height");
`endif

endmodule

FILE: sim/equirect_to_perspective_remap_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// equirect_to_perspective_remap_top_tb
// Feeds view pixels through the remap block under several view and panorama
// settings, with random gaps on the input and random back-pressure on the
// output. Every source address is checked against an in-bench fixed-point
// projection with its own CORDIC arctangent and its own copy of the registers.
// ----------------------------------------------------------------------------
module equirect_to_perspective_remap_top_tb;
	import e2p_pkg::*;

	localparam int ABITS = 16;
	localparam longint TURN = longint'(1) << ABITS;
	localparam int LAT = ABITS + 4;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] line;
	} pixel_t;

	typedef struct packed {
		logic [SRC_COORD_W-1:0] x;
		logic [SRC_COORD_W-1:0] y;
	} src_addr_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	e2p_cfg_if   cfg_ch();
	e2p_coord_if coord_ch();
	e2p_addr_if  addr_ch();

	equirect_to_perspective_remap_top i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch.sink),
		.coord (coord_ch.sink),
		.addr  (addr_ch.source)
	);

	// shadow of the view and panorama registers
	logic [12:0] view_w  = 13'd640;
	logic [12:0] view_h  = 13'd480;
	logic [14:0] pano_w  = 15'd4096;
	logic [14:0] pano_h  = 15'd2048;
	logic [8:0]  pan_r   = 9'd180;
	logic [7:0]  tilt_r  = 8'd0;

	pixel_t    pixel_q[$];
	src_addr_t addr_q[$];
	int        errors = 0;
	bit        accept_tgl = 1'b0;
	bit        accept_seen = 1'b0;
	bit        no_gaps = 1'b0;

	always #10 clk = ~clk;

	function automatic longint fdiv(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q -= 1;
		return q;
	endfunction

	function automatic longint deg_units(longint deg);
		longint m, u;
		m = deg < 0 ? -deg : deg;
		u = (m * TURN * 2 + 360) / 720;
		return deg < 0 ? -u : u;
	endfunction

	function automatic longint cordic_angle(longint d, longint f);
		longint x, y, z, t, xs, ys;
		x = f <<< 32;
		y = d <<< 32;
		z = 0;
		if (d == 0)
			return 0;
		for (int i = 0; i < ABITS; i++) begin
			t = (longint'(ATAN_TURN32[i]) + (longint'(1) << (31 - ABITS))) >> (32 - ABITS);
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x = x - ys;
				y = y + xs;
				z -= t;
			end else begin
				x = x + ys;
				y = y - xs;
				z += t;
			end
		end
		return z;
	endfunction

	function automatic src_addr_t project(pixel_t p);
		longint ow, oh, sw, sh, f, tilt, b, h, y, al, x;
		src_addr_t r;
		ow = view_w > 4096 ? 4096 : view_w;
		oh = view_h > 4096 ? 4096 : view_h;
		sw = pano_w > 16384 ? 16384 : pano_w;
		sh = pano_h > 16384 ? 16384 : pano_h;
		f = ow / 2;
		if (f < 1)
			f = 1;
		tilt = longint'($signed(tilt_r));
		b = deg_units(tilt) + cordic_angle(oh / 2 - longint'(p.line), f);
		h = sh / 2;
		y = fdiv(h * TURN - 4 * h * b + TURN / 2, TURN);
		if (y > sh - 1)
			y = sh - 1;
		if (y < 0)
			y = 0;
		al = deg_units(longint'(pan_r) % 360) + cordic_angle(longint'(p.col) - ow / 2, f);
		if (al < 0)
			al = -((-al) & (TURN - 1));
		else
			al = al & (TURN - 1);
		if (sw == 0) begin
			x = 0;
		end else begin
			x = fdiv(2 * sw * al + TURN, 2 * TURN);
			if (x < 0)
				x = sw + x;
			if (x >= sw)
				x = x - sw;
		end
		r.x = x[SRC_COORD_W-1:0];
		r.y = y[SRC_COORD_W-1:0];
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// coordinate driver
	always @(posedge clk) begin
		if (coord_ch.valid && coord_ch.ready) begin
			addr_q.push_back(project('{col: coord_ch.out_col, line: coord_ch.out_line}));
			accept_tgl = ~accept_tgl;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			coord_ch.valid    <= 1'b0;
			coord_ch.out_col  <= '0;
			coord_ch.out_line <= '0;
		end else if (!coord_ch.valid || accept_tgl != accept_seen) begin
			if (pixel_q.size() > 0 && (no_gaps || $urandom_range(99) >= 32)) begin
				pixel_t p;
				p = pixel_q.pop_front();
				coord_ch.valid    <= 1'b1;
				coord_ch.out_col  <= p.col;
				coord_ch.out_line <= p.line;
			end else begin
				coord_ch.valid <= 1'b0;
			end
		end
		accept_seen = accept_tgl;
	end

	// address monitor
	always @(negedge clk) begin
		if (!arst_n)
			addr_ch.ready <= 1'b0;
		else
			addr_ch.ready <= no_gaps || $urandom_range(99) >= 32;
	end

	always @(posedge clk) begin
		if (addr_ch.valid && addr_ch.ready) begin
			if (addr_q.size() == 0) begin
				report("unexpected beat, src_x", longint'(addr_ch.src_x), longint'(0));
			end else begin
				src_addr_t e;
				e = addr_q.pop_front();
				if (addr_ch.src_x !== e.x)
					report("src_x", longint'(addr_ch.src_x), longint'(e.x));
				if (addr_ch.src_y !== e.y)
					report("src_y", longint'(addr_ch.src_y), longint'(e.y));
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_OUT_WIDTH:  view_w = val[12:0];
			REG_OUT_HEIGHT: view_h = val[12:0];
			REG_SRC_WIDTH:  pano_w = val[14:0];
			REG_SRC_HEIGHT: pano_h = val[14:0];
			REG_PAN_DEG:    pan_r  = val[8:0];
			REG_TILT_DEG:   tilt_r = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_view(int ow, int oh, int sw, int sh, int pan, int tilt);
		write_reg(REG_OUT_WIDTH, CFG_DATA_W'(ow));
		write_reg(REG_OUT_HEIGHT, CFG_DATA_W'(oh));
		write_reg(REG_SRC_WIDTH, CFG_DATA_W'(sw));
		write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(sh));
		write_reg(REG_PAN_DEG, CFG_DATA_W'(pan));
		write_reg(REG_TILT_DEG, CFG_DATA_W'(tilt));
	endtask

	task automatic drain();
		while (pixel_q.size() > 0 || addr_q.size() > 0 || coord_ch.valid)
			@(posedge clk);
		repeat (LAT + 8) @(posedge clk);
	endtask

	task automatic add_random(int n);
		int cw, ch;
		pixel_t p;
		cw = view_w > 4096 ? 4096 : view_w;
		ch = view_h > 4096 ? 4096 : view_h;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 80) begin
				p.col  = cw > 0 ? COL_W'($urandom_range(cw - 1)) : '0;
				p.line = ch > 0 ? COL_W'($urandom_range(ch - 1)) : '0;
			end else begin
				p.col  = COL_W'($urandom);
				p.line = COL_W'($urandom);
			end
			pixel_q.push_back(p);
		end
	endtask

	task automatic add_corners();
		int cw, ch;
		cw = view_w > 4095 ? 4095 : view_w;
		ch = view_h > 4095 ? 4095 : view_h;
		pixel_q.push_back('{col: '0, line: '0});
		pixel_q.push_back('{col: 12'hFFF, line: 12'hFFF});
		pixel_q.push_back('{col: COL_W'(cw / 2), line: COL_W'(ch / 2)});
		pixel_q.push_back('{col: COL_W'(cw), line: '0});
		pixel_q.push_back('{col: '0, line: COL_W'(ch)});
	endtask

	initial begin
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, directed and random pixels
		add_corners();
		pixel_q.push_back('{col: 12'd319, line: 12'd240});
		pixel_q.push_back('{col: 12'd321, line: 12'd239});
		pixel_q.push_back('{col: 12'hFFF, line: 12'd0});
		pixel_q.push_back('{col: 12'd0, line: 12'hFFF});
		pixel_q.push_back('{col: 12'hAAA, line: 12'h555});
		pixel_q.push_back('{col: 12'h555, line: 12'hAAA});
		add_random(60);
		drain();

		// smallest sizes
		set_view(2, 1, 1, 1, 0, -44);
		add_corners();
		add_random(60);
		drain();

		// largest sizes, no gaps and no back-pressure at all
		set_view(4096, 4096, 16384, 16384, 359, 89);
		no_gaps = 1'b1;
		add_corners();
		add_random(80);
		drain();
		no_gaps = 1'b0;

		// zero and saturating sizes, wrap of pan, odd tilt
		set_view(0, 0, 0, 0, 511, -128);
		add_corners();
		add_random(30);
		drain();
		set_view(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 127);
		write_reg(3'd6, 16'h1234);
		write_reg(3'd7, 16'hFFFF);
		add_corners();
		add_random(40);
		drain();
		set_view(1, 8191, 32767, 0, 360, -1);
		add_random(30);
		drain();

		// random settings
		for (int ph = 0; ph < 8; ph++) begin
			set_view($urandom_range(4096, 2), $urandom_range(4096, 1),
				$urandom_range(16384, 1), $urandom_range(16384, 1),
				$urandom_range(359), $urandom_range(133) - 44);
			add_random(34);
			drain();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

endmodule
